/* sv/utf8c_pkg.sv */
// Shared types, constants and a helper function for the UTF-8 encoding classifier.
`default_nettype none

package utf8c_pkg;

  localparam int unsigned ByteW = 8;

  localparam logic [ByteW-1:0] BomByte0   = 8'hEF;
  localparam logic [ByteW-1:0] BomByte1   = 8'hBB;
  localparam logic [ByteW-1:0] BomByte2   = 8'hBF;
  localparam logic [ByteW-1:0] ContMask   = 8'hC0;
  localparam logic [ByteW-1:0] ContMark   = 8'h80;
  localparam logic [ByteW-1:0] Lead2Min   = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Min   = 8'hE0;
  localparam logic [ByteW-1:0] LeadBadMin = 8'hF0;

  localparam logic [1:0] BomDone = 2'd3;

  typedef enum logic [1:0] {
    VERDICT_ASCII   = 2'd0,
    VERDICT_UTF8    = 2'd1,
    VERDICT_BOM     = 2'd2,
    VERDICT_INVALID = 2'd3
  } verdict_t;

  typedef struct packed {
    logic             step;
    logic [ByteW-1:0] byte_value;
    logic             last_byte;
  } beat_t;

  function automatic logic [ByteW-1:0] bom_byte(input logic [1:0] phase);
    logic [ByteW-1:0] b;
    unique case (phase)
      2'd0:    b = BomByte0;
      2'd1:    b = BomByte1;
      default: b = BomByte2;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

/* sv/utf8_encoding_classifier.sv */
// Top level: classifies a byte stream as ASCII, UTF-8, UTF-8 with BOM or invalid.
// A verdict passes from the input register through the tracker into the result register and appears on m_tvalid.
// Throughput: one byte per cycle; input and result registers let a new byte
// enter while a verdict waits for m_tready, unless the held byte is final.
// Reset: rst is synchronous and active high; it empties both registers and
// returns the tracker to the start of a buffer.
`default_nettype none

module utf8_encoding_classifier
  import utf8c_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] byte_value
  input  wire logic       s_tlast,   // last_byte
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata    // [1:0] verdict, [7:2] zero
);

  beat_t    beat;
  verdict_t verdict;
  logic     out_ready;
  verdict_t verdict_reg;

  assign out_ready = !m_tvalid || m_tready;

  utf8c_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata[ByteW-1:0]),
    .in_last   (s_tlast),
    .out_ready (out_ready),
    .beat      (beat)
  );

  utf8c_tracker u_tracker (
    .clk     (clk),
    .rst     (rst),
    .beat    (beat),
    .verdict (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= beat.step && beat.last_byte;
    end
    if (out_ready && beat.step && beat.last_byte) begin
      verdict_reg <= verdict;
    end
  end

  assign m_tdata = {6'd0, verdict_reg};

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    (!$past(m_tvalid) && m_tvalid) |-> $past(beat.step && beat.last_byte))
    else $error("result beat without a final byte");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (beat.step && beat.last_byte) |-> out_ready)
    else $error("final byte retired while the result register is full");

endmodule

`default_nettype wire

/* sv/utf8c_in_stage.sv */
// Input register stage that holds one byte beat until the tracker takes it.
`default_nettype none

module utf8c_in_stage
  import utf8c_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [ByteW-1:0] in_byte,
  input  wire logic             in_last,
  input  wire logic             out_ready,
  output beat_t                 beat
);

  logic             held;
  logic [ByteW-1:0] held_byte;
  logic             held_last;
  logic             advance;

  assign advance  = held && (!held_last || out_ready);
  assign in_ready = !held || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
    if (in_ready && in_valid) begin
      held_byte <= in_byte;
      held_last <= in_last;
    end
  end

  assign beat.step       = advance;
  assign beat.byte_value = held_byte;
  assign beat.last_byte  = held_last;

endmodule

`default_nettype wire

/* sv/utf8c_tracker.sv */
// BOM and sequence state tracking with the verdict for the final byte.
`default_nettype none

module utf8c_tracker
  import utf8c_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire beat_t beat,
  output verdict_t   verdict
);

  logic [1:0] bom_phase, bom_phase_next;
  logic       bom_still_possible, bom_still_possible_next;
  logic [1:0] pending_continuations, pending_continuations_next;
  logic       error_seen, error_seen_next;
  logic       non_ascii_seen, non_ascii_seen_next;
  logic [ByteW-1:0] b;

  assign b = beat.byte_value;

  always_comb begin
    bom_phase_next             = bom_phase;
    bom_still_possible_next    = bom_still_possible;
    pending_continuations_next = pending_continuations;
    error_seen_next            = error_seen;
    non_ascii_seen_next        = non_ascii_seen;

    if (bom_still_possible && bom_phase != BomDone) begin
      if (b == bom_byte(bom_phase)) begin
        bom_phase_next = bom_phase + 2'd1;
      end else begin
        bom_still_possible_next = 1'b0;
      end
    end

    if (!error_seen) begin
      if (pending_continuations != 2'd0) begin
        if ((b & ContMask) == ContMark) begin
          pending_continuations_next = pending_continuations - 2'd1;
        end else begin
          error_seen_next = 1'b1;
        end
      end else if (b < ContMark) begin
        error_seen_next = 1'b0;
      end else if (b < Lead2Min) begin
        error_seen_next = 1'b1;
      end else if (b < Lead3Min) begin
        pending_continuations_next = 2'd1;
        non_ascii_seen_next        = 1'b1;
      end else if (b < LeadBadMin) begin
        pending_continuations_next = 2'd2;
        non_ascii_seen_next        = 1'b1;
      end else begin
        error_seen_next = 1'b1;
      end
    end

    priority if (bom_still_possible_next && bom_phase_next == BomDone) begin
      verdict = VERDICT_BOM;
    end else if (error_seen_next || pending_continuations_next != 2'd0) begin
      verdict = VERDICT_INVALID;
    end else if (non_ascii_seen_next) begin
      verdict = VERDICT_UTF8;
    end else begin
      verdict = VERDICT_ASCII;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (beat.step && beat.last_byte)) begin
      bom_phase             <= 2'd0;
      bom_still_possible    <= 1'b1;
      pending_continuations <= 2'd0;
      error_seen            <= 1'b0;
      non_ascii_seen        <= 1'b0;
    end else if (beat.step) begin
      bom_phase             <= bom_phase_next;
      bom_still_possible    <= bom_still_possible_next;
      pending_continuations <= pending_continuations_next;
      error_seen            <= error_seen_next;
      non_ascii_seen        <= non_ascii_seen_next;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (beat.step && beat.last_byte) |=>
      (bom_phase == 2'd0 && bom_still_possible && pending_continuations == 2'd0
       && !error_seen && !non_ascii_seen))
    else $error("tracker state not cleared after final byte");

  a_pending_range: assert property (@(posedge clk) disable iff (rst)
    pending_continuations != 2'd3)
    else $error("more than two continuations pending");

  a_error_freezes: assert property (@(posedge clk) disable iff (rst)
    (error_seen && !(beat.step && beat.last_byte)) |=>
      (error_seen && pending_continuations == $past(pending_continuations)))
    else $error("sequence state moved after an error");

endmodule

`default_nettype wire
